>>> src/fpho_pkg.sv
`timescale 1ns / 1ps
// Shared types, register codes and constants for the five-point heat operator.
// Depends on nothing; every other file refers to it by scoped names.
package fpho_pkg;

   localparam int COL_W  = 10;
   localparam int ROW_W  = 16;
   localparam int LAP_W  = 35;
   localparam int WIDE_W = 53;

   localparam int RIGHT_TAP    = 0;
   localparam int CENTRE_TAP   = 1;
   localparam int LEFT_TAP     = 2;
   localparam int WINDOW_CELLS = LEFT_TAP;

   localparam logic [1:0] REG_GRID_WIDTH  = 2'd0;
   localparam logic [1:0] REG_GRID_HEIGHT = 2'd1;
   localparam logic [1:0] REG_STEP_COEF   = 2'd2;
   localparam logic [1:0] REG_OP_SELECT   = 2'd3;

   localparam logic [COL_W-1:0] WIDTH_LIMIT  = 10'd1022;
   localparam logic [ROW_W-1:0] HEIGHT_LIMIT = 16'd65534;
   localparam logic [COL_W-1:0] AHEAD_START  = 10'd2;

   typedef struct packed {
      logic signed [31:0] mid;
      logic signed [31:0] up;
   } tap_type;

   typedef struct packed {
      logic [COL_W-1:0] width;
      logic [ROW_W-1:0] height;
   } geom_type;

   typedef struct packed {
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      logic             last;
   } meta_type;

   typedef struct packed {
      logic signed [31:0] centre;
      logic signed [31:0] left;
      logic signed [31:0] right;
      logic signed [31:0] up;
      logic signed [31:0] below;
      meta_type           meta;
   } opnd_type;

   function automatic logic signed [31:0] saturate(input logic signed [WIDE_W-1:0] v);
      logic signed [31:0] r;
      if ((v[WIDE_W-1:31] == '0) || (v[WIDE_W-1:31] == '1)) begin
         r = v[31:0];
      end else if (v[WIDE_W-1]) begin
         r = 32'sh8000_0000;
      end else begin
         r = 32'sh7FFF_FFFF;
      end
      return r;
   endfunction

endpackage

>>> src/five_point_heat_operator_top.sv
`timescale 1ns / 1ps
// Five-point heat operator top level: register port, window and arithmetic pipeline.
// Depends on fpho_pkg, fpho_window and fpho_arith.
// Throughput is one sample per cycle while the result side does not stall, set by one write
// and one read of each line store per sample. A result passes the operand, Laplacian, both product
// and result registers before it is shown on rsp_valid; a stall on the result side holds it there.
// Reset clears the position counters, the pipeline and the registers; the line stores are not
// cleared and need no clearing pass, as the first two padded rows rewrite every entry read.
module five_point_heat_operator_top #(
   parameter int MAX_ROW = 1024
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [31:0]         req_sample,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [31:0]         rsp_value,
   output logic [fpho_pkg::COL_W-1:0] rsp_col,
   output logic [fpho_pkg::ROW_W-1:0] rsp_row,
   output logic                       rsp_last_of_frame,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [3:0]                 csr_paddr,
   input  logic [31:0]                csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);

   localparam int WidthCapInt = (MAX_ROW - 2 < int'(fpho_pkg::WIDTH_LIMIT))
                              ? MAX_ROW - 2 : int'(fpho_pkg::WIDTH_LIMIT);
   localparam logic [fpho_pkg::COL_W-1:0] WIDTH_CAP = fpho_pkg::COL_W'(WidthCapInt);

   logic [fpho_pkg::COL_W-1:0] grid_width_ff, grid_width_in;
   logic [fpho_pkg::ROW_W-1:0] grid_height_ff, grid_height_in;
   logic signed [31:0]         step_coef_ff, step_coef_in;
   logic                       op_select_ff, op_select_in;

   logic               csr_write;
   logic [1:0]         csr_index;
   logic               restart;
   logic               accept;
   logic               take;
   logic               can_take;
   logic               has_result;
   fpho_pkg::geom_type geom;
   fpho_pkg::opnd_type opnd;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = csr_paddr[3:2];

   always_comb begin
      grid_width_in  = grid_width_ff;
      grid_height_in = grid_height_ff;
      step_coef_in   = step_coef_ff;
      op_select_in   = op_select_ff;
      restart        = 1'b0;
      if (csr_write) begin
         unique case (csr_index)
            fpho_pkg::REG_GRID_WIDTH: begin
               grid_width_in = csr_pwdata[fpho_pkg::COL_W-1:0];
               restart       = 1'b1;
            end
            fpho_pkg::REG_GRID_HEIGHT: begin
               grid_height_in = csr_pwdata[fpho_pkg::ROW_W-1:0];
               restart        = 1'b1;
            end
            fpho_pkg::REG_STEP_COEF: begin
               step_coef_in = csr_pwdata;
            end
            fpho_pkg::REG_OP_SELECT: begin
               op_select_in = csr_pwdata[0];
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= 10'd1022;
         grid_height_ff <= 16'd1022;
         step_coef_ff   <= 32'sd65536;
         op_select_ff   <= 1'b1;
      end else begin
         grid_width_ff  <= grid_width_in;
         grid_height_ff <= grid_height_in;
         step_coef_ff   <= step_coef_in;
         op_select_ff   <= op_select_in;
      end
   end

   always_comb begin
      unique case (csr_index)
         fpho_pkg::REG_GRID_WIDTH:  csr_prdata = {22'd0, grid_width_ff};
         fpho_pkg::REG_GRID_HEIGHT: csr_prdata = {16'd0, grid_height_ff};
         fpho_pkg::REG_STEP_COEF:   csr_prdata = step_coef_ff;
         fpho_pkg::REG_OP_SELECT:   csr_prdata = {31'd0, op_select_ff};
      endcase
   end

   always_comb begin
      if (grid_width_ff == '0) begin
         geom.width = 10'd1;
      end else if (grid_width_ff > WIDTH_CAP) begin
         geom.width = WIDTH_CAP;
      end else begin
         geom.width = grid_width_ff;
      end
      if (grid_height_ff == '0) begin
         geom.height = 16'd1;
      end else if (grid_height_ff > fpho_pkg::HEIGHT_LIMIT) begin
         geom.height = fpho_pkg::HEIGHT_LIMIT;
      end else begin
         geom.height = grid_height_ff;
      end
   end

   assign req_ready = can_take;
   assign accept    = req_valid & req_ready;
   assign take      = accept & has_result;

   fpho_window #(
      .MAX_ROW (MAX_ROW)
   ) u_window (
      .clock      (clock),
      .reset      (reset),
      .geom       (geom),
      .restart    (restart),
      .accept     (accept),
      .sample     (req_sample),
      .opnd       (opnd),
      .has_result (has_result)
   );

   fpho_arith u_arith (
      .clock             (clock),
      .reset             (reset),
      .take              (take),
      .opnd              (opnd),
      .coef              (step_coef_ff),
      .op_select         (op_select_ff),
      .can_take          (can_take),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_value         (rsp_value),
      .rsp_col           (rsp_col),
      .rsp_row           (rsp_row),
      .rsp_last_of_frame (rsp_last_of_frame)
   );

endmodule

>>> src/fpho_cell.sv
`timescale 1ns / 1ps
// One window cell: holds the middle-row and upper-row samples of one column.
// Depends on fpho_pkg for the tap type.
module fpho_cell (
   input  logic              clock,
   input  logic              shift,
   input  fpho_pkg::tap_type tap_i,
   output fpho_pkg::tap_type tap_o
);

   fpho_pkg::tap_type tap_ff;
   fpho_pkg::tap_type tap_in;

   assign tap_in = shift ? tap_i : tap_ff;

   always_ff @(posedge clock) begin
      tap_ff <= tap_in;
   end

   assign tap_o = tap_ff;

endmodule

>>> src/fpho_window.sv
`timescale 1ns / 1ps
// Line stores, raster position counters and the chain of window cells.
// Depends on fpho_pkg and fpho_cell.
module fpho_window #(
   parameter int MAX_ROW = 1024
) (
   input  logic                clock,
   input  logic                reset,
   input  fpho_pkg::geom_type  geom,
   input  logic                restart,
   input  logic                accept,
   input  logic signed [31:0]  sample,
   output fpho_pkg::opnd_type  opnd,
   output logic                has_result
);

   localparam int DEPTH = (MAX_ROW < (1 << fpho_pkg::COL_W)) ? MAX_ROW : (1 << fpho_pkg::COL_W);
   localparam int AW    = $clog2(DEPTH);

   logic signed [31:0] middle_mem [DEPTH];
   logic signed [31:0] upper_mem  [DEPTH];

   logic [fpho_pkg::COL_W-1:0] col_ff, col_in, ahead_ff, ahead_in, col_end;
   logic [fpho_pkg::ROW_W-1:0] row_ff, row_in, row_end;

   fpho_pkg::tap_type fetch_ff;
   fpho_pkg::tap_type tap [fpho_pkg::WINDOW_CELLS+1];

   assign col_end = geom.width + 10'd1;
   assign row_end = geom.height + 16'd1;

   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      ahead_in = ahead_ff;
      if (restart) begin
         col_in   = '0;
         row_in   = '0;
         ahead_in = fpho_pkg::AHEAD_START;
      end else if (accept) begin
         if (col_ff == col_end) begin
            col_in = '0;
            row_in = (row_ff == row_end) ? '0 : row_ff + 16'd1;
         end else begin
            col_in = col_ff + 10'd1;
         end
         ahead_in = (ahead_ff == col_end) ? '0 : ahead_ff + 10'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         ahead_ff <= fpho_pkg::AHEAD_START;
      end else begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         ahead_ff <= ahead_in;
      end
   end

   // The stores are read two transfers ahead so that the window is full when a sample arrives.
   always_ff @(posedge clock) begin
      if (accept) begin
         middle_mem[col_ff[AW-1:0]] <= sample;
         upper_mem[col_ff[AW-1:0]]  <= tap[fpho_pkg::CENTRE_TAP].mid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         fetch_ff.mid <= middle_mem[ahead_ff[AW-1:0]];
         fetch_ff.up  <= upper_mem[ahead_ff[AW-1:0]];
      end
   end

   assign tap[fpho_pkg::RIGHT_TAP] = fetch_ff;

   for (genvar i = 0; i < fpho_pkg::WINDOW_CELLS; i++) begin : g_cell
      fpho_cell u_cell (
         .clock (clock),
         .shift (accept),
         .tap_i (tap[i]),
         .tap_o (tap[i+1])
      );
   end

   always_comb begin
      opnd.centre    = tap[fpho_pkg::CENTRE_TAP].mid;
      opnd.up        = tap[fpho_pkg::CENTRE_TAP].up;
      opnd.left      = tap[fpho_pkg::LEFT_TAP].mid;
      opnd.right     = tap[fpho_pkg::RIGHT_TAP].mid;
      opnd.below     = sample;
      opnd.meta.col  = col_ff;
      opnd.meta.row  = row_ff - 16'd1;
      opnd.meta.last = (row_ff == row_end) && (col_ff == geom.width);
   end

   assign has_result = (row_ff >= 16'd2) && (col_ff != '0) && (col_ff <= geom.width);

endmodule

>>> src/fpho_arith.sv
`timescale 1ns / 1ps
// Arithmetic pipeline: Laplacian, split coefficient product, update and saturation, or the saturated
// Laplacian alone when op_select is clear. Depends on fpho_pkg; the last stage is the result register.
module fpho_arith (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       take,
   input  fpho_pkg::opnd_type         opnd,
   input  logic signed [31:0]         coef,
   input  logic                       op_select,
   output logic                       can_take,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [31:0]         rsp_value,
   output logic [fpho_pkg::COL_W-1:0] rsp_col,
   output logic [fpho_pkg::ROW_W-1:0] rsp_row,
   output logic                       rsp_last_of_frame
);

   logic v1_ff, v2_ff, v3_ff, v4_ff, vo_ff;
   logic v1_in, v2_in, v3_in, v4_in, vo_in;
   logic adv1, adv2, adv3, adv4, advo;

   fpho_pkg::opnd_type opnd_ff;

   logic signed [fpho_pkg::LAP_W-1:0] lap2_ff, lap2_in, lap3_ff, lap4_ff;
   logic signed [31:0]                cen2_ff, cen3_ff, cen4_ff;
   fpho_pkg::meta_type                meta2_ff, meta3_ff, meta4_ff, meta_out_ff;

   logic signed [18:0] lap_hi;
   logic signed [16:0] lap_lo;
   logic signed [50:0] pk_hi_ff, pk_hi_in;
   logic signed [48:0] pk_lo_ff, pk_lo_in, lo_round;
   logic signed [51:0] prod_ff, prod_in;
   logic signed [fpho_pkg::WIDE_W-1:0] sum;
   logic signed [31:0] value_ff, value_in;

   assign advo     = !vo_ff || rsp_ready;
   assign adv4     = !v4_ff || advo;
   assign adv3     = !v3_ff || adv4;
   assign adv2     = !v2_ff || adv3;
   assign adv1     = !v1_ff || adv2;
   assign can_take = adv1;

   assign v1_in = adv1 ? take  : v1_ff;
   assign v2_in = adv2 ? v1_ff : v2_ff;
   assign v3_in = adv3 ? v2_ff : v3_ff;
   assign v4_in = adv4 ? v3_ff : v4_ff;
   assign vo_in = advo ? v4_ff : vo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
         vo_ff <= vo_in;
      end
   end

   assign lap2_in = {opnd_ff.centre[31], opnd_ff.centre, 2'b00}
                  - {{3{opnd_ff.left[31]}},  opnd_ff.left}
                  - {{3{opnd_ff.right[31]}}, opnd_ff.right}
                  - {{3{opnd_ff.up[31]}},    opnd_ff.up}
                  - {{3{opnd_ff.below[31]}}, opnd_ff.below};

   assign lap_hi   = lap2_ff[fpho_pkg::LAP_W-1:16];
   assign lap_lo   = {1'b0, lap2_ff[15:0]};
   assign pk_hi_in = coef * lap_hi;
   assign pk_lo_in = coef * lap_lo;

   assign lo_round = pk_lo_ff + 49'sd32768;
   assign prod_in  = 52'(pk_hi_ff) + 52'(lo_round >>> 16);

   assign sum      = 53'(cen4_ff) + 53'(prod_ff);
   assign value_in = op_select ? fpho_pkg::saturate(sum)
                               : fpho_pkg::saturate(53'(lap4_ff));

   always_ff @(posedge clock) begin
      if (adv1) begin
         opnd_ff <= opnd;
      end
      if (adv2) begin
         lap2_ff  <= lap2_in;
         cen2_ff  <= opnd_ff.centre;
         meta2_ff <= opnd_ff.meta;
      end
      if (adv3) begin
         pk_hi_ff <= pk_hi_in;
         pk_lo_ff <= pk_lo_in;
         lap3_ff  <= lap2_ff;
         cen3_ff  <= cen2_ff;
         meta3_ff <= meta2_ff;
      end
      if (adv4) begin
         prod_ff  <= prod_in;
         lap4_ff  <= lap3_ff;
         cen4_ff  <= cen3_ff;
         meta4_ff <= meta3_ff;
      end
      if (advo) begin
         value_ff    <= value_in;
         meta_out_ff <= meta4_ff;
      end
   end

   assign rsp_valid         = vo_ff;
   assign rsp_value         = value_ff;
   assign rsp_col           = meta_out_ff.col;
   assign rsp_row           = meta_out_ff.row;
   assign rsp_last_of_frame = meta_out_ff.last;

endmodule
